// File: rtl/tcw_pkg.sv
package tcw_pkg;

   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 32;
   localparam int CELLS = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int OFF_W = $clog2(CELLS + 1);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int DIV_STEPS = ADDR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int CURSOR_W = 12;
   localparam int CFG_COLS_W = 8;
   localparam int CFG_ROWS_W = 6;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 8;

   localparam logic [CFG_COLS_W-1:0] COLS_RESET = CFG_COLS_W'(80);
   localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = CFG_ROWS_W'(25);

   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_COLS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_ROWS = CSR_INDEX_W'(1);

   localparam logic [MODE_W-1:0] MODE_PUT = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_CLEAR = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_READ = MODE_W'(2);

   localparam logic [BYTE_W-1:0] CH_NUL = BYTE_W'(0);
   localparam logic [BYTE_W-1:0] CH_NEWLINE = BYTE_W'(10);
   localparam logic [BYTE_W-1:0] CH_SPACE = BYTE_W'(32);
   localparam logic [BYTE_W-1:0] ATTR_DEFAULT = BYTE_W'(15);
   localparam logic [BYTE_W-1:0] COLOR_MAX = BYTE_W'(15);

   localparam int PC_W = 5;
   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_FETCH = pc_type'(0);
   localparam pc_type PC_CALC = pc_type'(1);
   localparam pc_type PC_PICK = pc_type'(2);
   localparam pc_type PC_WRITE = pc_type'(3);
   localparam pc_type PC_SCR_INIT = pc_type'(4);
   localparam pc_type PC_SCR_TEST = pc_type'(5);
   localparam pc_type PC_SCR_RD = pc_type'(6);
   localparam pc_type PC_SCR_WR = pc_type'(7);
   localparam pc_type PC_FILL = pc_type'(8);
   localparam pc_type PC_MOVE = pc_type'(9);
   localparam pc_type PC_DIV_INIT = pc_type'(10);
   localparam pc_type PC_DIV_STEP = pc_type'(11);
   localparam pc_type PC_NL_ADV = pc_type'(12);
   localparam pc_type PC_NL_SCROLL = pc_type'(13);
   localparam pc_type PC_CLR_INIT = pc_type'(14);
   localparam pc_type PC_CLR_WR = pc_type'(15);
   localparam pc_type PC_RESP = pc_type'(16);
   localparam pc_type PC_RESP_WAIT = pc_type'(17);
   localparam pc_type PC_RD = pc_type'(18);

   typedef enum logic [4:0] {
      OP_NOP,
      OP_LATCH,
      OP_CALC,
      OP_PICK,
      OP_WRITE,
      OP_SCR_INIT,
      OP_SCR_RD,
      OP_SCR_WR,
      OP_FILL,
      OP_MOVE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_NL_ADV,
      OP_CLR_INIT,
      OP_CLR_WR,
      OP_RESP,
      OP_RD
   } op_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DISPATCH,
      COND_NO_SCROLL,
      COND_MOVE_DONE,
      COND_SWEEP_BUSY,
      COND_DIV_BUSY,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type op;
      cond_type cond;
      pc_type target;
   } ucode_type;

   typedef struct packed {
      logic req_valid;
      logic out_free;
      logic no_scroll;
      logic move_done;
      logic sweep_busy;
      logic div_busy;
      pc_type dispatch_pc;
   } seq_flags_type;

   typedef struct packed {
      logic we_char;
      logic we_attr;
      logic [ADDR_W-1:0] waddr;
      logic [BYTE_W-1:0] wchar;
      logic [BYTE_W-1:0] wattr;
      logic re;
      logic [ADDR_W-1:0] raddr;
   } store_ctl_type;

   function automatic ucode_type make_word(input op_type op, input cond_type cond,
                                           input pc_type target);
      ucode_type w;
      w.op = op;
      w.cond = cond;
      w.target = target;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      unique case (pc)
         PC_FETCH:     w = make_word(OP_LATCH, COND_NO_REQ, PC_FETCH);
         PC_CALC:      w = make_word(OP_CALC, COND_NONE, PC_FETCH);
         PC_PICK:      w = make_word(OP_PICK, COND_DISPATCH, PC_FETCH);
         PC_WRITE:     w = make_word(OP_WRITE, COND_NO_SCROLL, PC_MOVE);
         PC_SCR_INIT:  w = make_word(OP_SCR_INIT, COND_NONE, PC_FETCH);
         PC_SCR_TEST:  w = make_word(OP_NOP, COND_MOVE_DONE, PC_FILL);
         PC_SCR_RD:    w = make_word(OP_SCR_RD, COND_NONE, PC_FETCH);
         PC_SCR_WR:    w = make_word(OP_SCR_WR, COND_ALWAYS, PC_SCR_TEST);
         PC_FILL:      w = make_word(OP_FILL, COND_SWEEP_BUSY, PC_FILL);
         PC_MOVE:      w = make_word(OP_MOVE, COND_ALWAYS, PC_RESP);
         PC_DIV_INIT:  w = make_word(OP_DIV_INIT, COND_NONE, PC_FETCH);
         PC_DIV_STEP:  w = make_word(OP_DIV_STEP, COND_DIV_BUSY, PC_DIV_STEP);
         PC_NL_ADV:    w = make_word(OP_NL_ADV, COND_NO_SCROLL, PC_MOVE);
         PC_NL_SCROLL: w = make_word(OP_NOP, COND_ALWAYS, PC_SCR_INIT);
         PC_CLR_INIT:  w = make_word(OP_CLR_INIT, COND_NONE, PC_FETCH);
         PC_CLR_WR:    w = make_word(OP_CLR_WR, COND_SWEEP_BUSY, PC_CLR_WR);
         PC_RESP:      w = make_word(OP_RESP, COND_OUT_FREE, PC_FETCH);
         PC_RESP_WAIT: w = make_word(OP_NOP, COND_ALWAYS, PC_RESP);
         PC_RD:        w = make_word(OP_RD, COND_ALWAYS, PC_RESP);
         default:      w = make_word(OP_NOP, COND_ALWAYS, PC_FETCH);
      endcase
      return w;
   endfunction

   function automatic pc_type dispatch_target(input logic [MODE_W-1:0] mode,
                                              input logic [BYTE_W-1:0] ch);
      pc_type t;
      unique case (mode)
         MODE_PUT: begin
            if (ch == CH_NUL) begin
               t = PC_RESP;
            end else if (ch == CH_NEWLINE) begin
               t = PC_DIV_INIT;
            end else begin
               t = PC_WRITE;
            end
         end
         MODE_CLEAR: t = PC_CLR_INIT;
         MODE_READ:  t = PC_RD;
         default:    t = PC_RESP;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/tcw_req_if.sv
interface tcw_req_if;
   logic valid;
   logic ready;
   logic [tcw_pkg::MODE_W-1:0] mode;
   logic [tcw_pkg::BYTE_W-1:0] char_code;
   logic [tcw_pkg::BYTE_W-1:0] col_pos;
   logic [tcw_pkg::BYTE_W-1:0] row_pos;
   logic [tcw_pkg::BYTE_W-1:0] fg_code;
   logic [tcw_pkg::BYTE_W-1:0] bg_code;
   logic move_cursor;

   modport source (output valid, mode, char_code, col_pos, row_pos, fg_code, bg_code,
                   move_cursor, input ready);
   modport sink (input valid, mode, char_code, col_pos, row_pos, fg_code, bg_code,
                 move_cursor, output ready);
endinterface

// File: rtl/tcw_rsp_if.sv
interface tcw_rsp_if;
   logic valid;
   logic ready;
   logic [tcw_pkg::CURSOR_W-1:0] cursor_pos;
   logic [tcw_pkg::BYTE_W-1:0] cell_char;
   logic [tcw_pkg::BYTE_W-1:0] cell_attr;
   logic scrolled;

   modport source (output valid, cursor_pos, cell_char, cell_attr, scrolled, input ready);
   modport sink (input valid, cursor_pos, cell_char, cell_attr, scrolled, output ready);
endinterface

// File: rtl/tcw_csr_if.sv
interface tcw_csr_if;
   logic valid;
   logic ready;
   logic [tcw_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [tcw_pkg::CSR_DATA_W-1:0] reg_data;

   modport source (output valid, reg_index, reg_data, input ready);
   modport sink (input valid, reg_index, reg_data, output ready);
endinterface

// File: rtl/text_console_writer.sv
// Channel  Direction  Handshake     Word
// req      in         valid/ready   mode, char_code, col_pos, row_pos, fg_code, bg_code,
//                                   move_cursor
// rsp      out        valid/ready   cursor_pos, cell_char, cell_attr, scrolled
// csr      in         valid/ready   reg_index, reg_data (ready is always high)
//
// One word is taken at a time; a microcode step counter walks each request.
// A read fetches one cell and a NUL or mode 3 goes straight to the response; a plain
// put writes one cell. A newline runs the bit-serial row divider to find the column and
// moves to the next row. A scroll copies each cell up one row, then fills the characters
// of the last row with spaces; clear blanks each active cell in turn through the single write port of the cell store.
// Reset is synchronous; the stores are not cleared. A stalled response is held
// in the output register and the sequencer waits at its response step.
module text_console_writer (
   input  logic       clock,
   input  logic       reset,
   tcw_req_if.sink    req_ch,
   tcw_rsp_if.source  rsp_ch,
   tcw_csr_if.sink    csr_ch
);
   import tcw_pkg::*;

   ucode_type      word;
   seq_flags_type  flags;
   store_ctl_type  store_ctl;
   logic [BYTE_W-1:0] rd_char;
   logic [BYTE_W-1:0] rd_attr;

   logic [CFG_COLS_W-1:0] active_cols_ff;
   logic [CFG_ROWS_W-1:0] active_rows_ff;

   logic [MODE_W-1:0]   mode_ff;
   logic [BYTE_W-1:0]   char_ff;
   logic [BYTE_W-1:0]   col_ff;
   logic [BYTE_W-1:0]   row_ff;
   logic [BYTE_W-1:0]   attr_ff;
   logic                mv_ff;
   logic [COLS_W-1:0]   cols_ff;
   logic [OFF_W-1:0]    total_ff;
   logic [OFF_W-1:0]    lin_ff;
   logic                inrange_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [OFF_W-1:0]    off_in;
   logic [OFF_W-1:0]    idx_ff;
   logic [OFF_W-1:0]    idx_in;
   logic [ADDR_W-1:0]   div_sr_ff;
   logic [ADDR_W-1:0]   div_sr_in;
   logic [COLS_W-1:0]   rem_ff;
   logic [COLS_W-1:0]   rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIV_CNT_W-1:0] div_cnt_in;
   logic [CURSOR_W-1:0] cursor_ff;
   logic [CURSOR_W-1:0] cursor_in;
   logic                scrolled_ff;
   logic                scrolled_in;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff;
   logic [BYTE_W-1:0]   rsp_char_ff;
   logic [BYTE_W-1:0]   rsp_attr_ff;
   logic                rsp_scrolled_ff;

   logic                req_acc;
   logic [COLS_W-1:0]   cols_eff;
   logic [ROWS_W-1:0]   rows_eff;
   logic [COLS_W+ROWS_W-1:0] total_prod;
   logic [COLS_W+ROWS_W-1:0] row_prod;
   logic                inrange;
   logic [BYTE_W-1:0]   attr_new;
   logic [OFF_W-1:0]    pick_off;
   logic [OFF_W-1:0]    adv_off;
   logic [OFF_W:0]      src_sum;
   logic [OFF_W-1:0]    idx_inc;
   logic [COLS_W:0]     trial;

   tcw_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .word  (word)
   );

   tcw_cell_store u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_char (rd_char),
      .rd_attr (rd_attr)
   );

   assign req_ch.ready = (word.op == OP_LATCH);
   assign req_acc = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.cursor_pos = rsp_cursor_ff;
   assign rsp_ch.cell_char = rsp_char_ff;
   assign rsp_ch.cell_attr = rsp_attr_ff;
   assign rsp_ch.scrolled = rsp_scrolled_ff;

   always_comb begin
      if (active_cols_ff == '0) begin
         cols_eff = COLS_W'(1);
      end else if (int'(active_cols_ff) > MAX_COLS) begin
         cols_eff = COLS_W'(MAX_COLS);
      end else begin
         cols_eff = COLS_W'(active_cols_ff);
      end
      if (active_rows_ff == '0) begin
         rows_eff = ROWS_W'(1);
      end else if (int'(active_rows_ff) > MAX_ROWS) begin
         rows_eff = ROWS_W'(MAX_ROWS);
      end else begin
         rows_eff = ROWS_W'(active_rows_ff);
      end
   end

   assign total_prod = (COLS_W+ROWS_W)'(cols_eff) * (COLS_W+ROWS_W)'(rows_eff);
   assign row_prod = (COLS_W+ROWS_W)'(cols_eff) * (COLS_W+ROWS_W)'(row_ff[ROWS_W-1:0]);
   assign inrange = (int'(col_ff) < int'(cols_eff)) && (int'(row_ff) < int'(rows_eff));

   assign attr_new = (req_ch.fg_code > COLOR_MAX || req_ch.bg_code > COLOR_MAX)
                     ? ATTR_DEFAULT : {req_ch.fg_code[3:0], req_ch.bg_code[3:0]};

   always_comb begin
      if (inrange_ff) begin
         pick_off = lin_ff;
      end else if (OFF_W'(cursor_ff) >= total_ff) begin
         pick_off = total_ff - OFF_W'(1);
      end else begin
         pick_off = OFF_W'(cursor_ff);
      end
   end

   assign adv_off = (word.op == OP_NL_ADV)
                    ? off_ff - OFF_W'(rem_ff) + OFF_W'(cols_ff)
                    : off_ff + OFF_W'(1);
   assign src_sum = (OFF_W+1)'(idx_ff) + (OFF_W+1)'(cols_ff);
   assign idx_inc = idx_ff + OFF_W'(1);
   assign trial = {rem_ff, div_sr_ff[ADDR_W-1]};

   always_comb begin
      flags.req_valid = req_ch.valid;
      flags.out_free = !rsp_valid_ff || rsp_ch.ready;
      flags.no_scroll = adv_off < total_ff;
      flags.move_done = src_sum >= (OFF_W+1)'(total_ff);
      flags.sweep_busy = idx_inc < total_ff;
      flags.div_busy = div_cnt_ff != '0;
      flags.dispatch_pc = dispatch_target(mode_ff, char_ff);
   end

   always_comb begin
      store_ctl = '0;
      unique case (word.op)
         OP_WRITE: begin
            store_ctl.we_char = 1'b1;
            store_ctl.we_attr = 1'b1;
            store_ctl.waddr = off_ff[ADDR_W-1:0];
            store_ctl.wchar = char_ff;
            store_ctl.wattr = attr_ff;
         end
         OP_SCR_RD: begin
            store_ctl.re = 1'b1;
            store_ctl.raddr = src_sum[ADDR_W-1:0];
         end
         OP_SCR_WR: begin
            store_ctl.we_char = 1'b1;
            store_ctl.we_attr = 1'b1;
            store_ctl.waddr = idx_ff[ADDR_W-1:0];
            store_ctl.wchar = rd_char;
            store_ctl.wattr = rd_attr;
         end
         OP_FILL: begin
            store_ctl.we_char = 1'b1;
            store_ctl.waddr = idx_ff[ADDR_W-1:0];
            store_ctl.wchar = CH_SPACE;
         end
         OP_CLR_WR: begin
            store_ctl.we_char = 1'b1;
            store_ctl.we_attr = 1'b1;
            store_ctl.waddr = idx_ff[ADDR_W-1:0];
            store_ctl.wchar = CH_SPACE;
            store_ctl.wattr = ATTR_DEFAULT;
         end
         OP_RD: begin
            store_ctl.re = 1'b1;
            store_ctl.raddr = off_ff[ADDR_W-1:0];
         end
         default: store_ctl = '0;
      endcase
   end

   always_comb begin
      off_in = off_ff;
      idx_in = idx_ff;
      div_sr_in = div_sr_ff;
      rem_in = rem_ff;
      div_cnt_in = div_cnt_ff;
      cursor_in = cursor_ff;
      scrolled_in = scrolled_ff;
      unique case (word.op)
         OP_LATCH: begin
            if (req_acc) begin
               scrolled_in = 1'b0;
            end
         end
         OP_PICK: off_in = pick_off;
         OP_WRITE: off_in = adv_off;
         OP_NL_ADV: off_in = adv_off;
         OP_SCR_INIT: begin
            idx_in = '0;
            off_in = off_ff - OFF_W'(cols_ff);
            scrolled_in = 1'b1;
         end
         OP_SCR_WR: idx_in = idx_inc;
         OP_FILL: idx_in = idx_inc;
         OP_MOVE: begin
            if (mv_ff) begin
               cursor_in = off_ff[CURSOR_W-1:0];
            end
         end
         OP_DIV_INIT: begin
            div_sr_in = off_ff[ADDR_W-1:0];
            rem_in = '0;
            div_cnt_in = DIV_CNT_W'(DIV_STEPS - 1);
         end
         OP_DIV_STEP: begin
            div_sr_in = {div_sr_ff[ADDR_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (trial >= (COLS_W+1)'(cols_ff)) begin
               rem_in = COLS_W'(trial - (COLS_W+1)'(cols_ff));
            end else begin
               rem_in = trial[COLS_W-1:0];
            end
         end
         OP_CLR_INIT: begin
            idx_in = '0;
            cursor_in = '0;
         end
         OP_CLR_WR: idx_in = idx_inc;
         default: off_in = off_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (word.op == OP_RESP && flags.out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_cols_ff <= COLS_RESET;
         active_rows_ff <= ROWS_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.reg_index)
            CSR_ACTIVE_COLS: active_cols_ff <= csr_ch.reg_data[CFG_COLS_W-1:0];
            CSR_ACTIVE_ROWS: active_rows_ff <= csr_ch.reg_data[CFG_ROWS_W-1:0];
            default: active_cols_ff <= active_cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_ff <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      idx_ff <= idx_in;
      div_sr_ff <= div_sr_in;
      rem_ff <= rem_in;
      div_cnt_ff <= div_cnt_in;
      scrolled_ff <= scrolled_in;
      if (req_acc) begin
         mode_ff <= req_ch.mode;
         char_ff <= req_ch.char_code;
         col_ff <= req_ch.col_pos;
         row_ff <= req_ch.row_pos;
         attr_ff <= attr_new;
         mv_ff <= req_ch.move_cursor;
      end
      if (word.op == OP_CALC) begin
         cols_ff <= cols_eff;
         total_ff <= OFF_W'(total_prod);
         lin_ff <= OFF_W'(col_ff) + OFF_W'(row_prod);
         inrange_ff <= inrange;
      end
      if (word.op == OP_RESP && flags.out_free) begin
         rsp_cursor_ff <= cursor_ff;
         rsp_char_ff <= (mode_ff == MODE_READ) ? rd_char : '0;
         rsp_attr_ff <= (mode_ff == MODE_READ) ? rd_attr : '0;
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

endmodule

// File: rtl/tcw_cell_store.sv
module tcw_cell_store (
   input  logic                          clock,
   input  tcw_pkg::store_ctl_type        ctl,
   output logic [tcw_pkg::BYTE_W-1:0]    rd_char,
   output logic [tcw_pkg::BYTE_W-1:0]    rd_attr
);
   import tcw_pkg::*;

   logic [BYTE_W-1:0] char_mem [CELLS];
   logic [BYTE_W-1:0] attr_mem [CELLS];

   always_ff @(posedge clock) begin
      if (ctl.we_char) begin
         char_mem[ctl.waddr] <= ctl.wchar;
      end
      if (ctl.re) begin
         rd_char <= char_mem[ctl.raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.we_attr) begin
         attr_mem[ctl.waddr] <= ctl.wattr;
      end
      if (ctl.re) begin
         rd_attr <= attr_mem[ctl.raddr];
      end
   end

endmodule

// File: rtl/tcw_sequencer.sv
module tcw_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  tcw_pkg::seq_flags_type  flags,
   output tcw_pkg::ucode_type      word
);
   import tcw_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   pc_type pc_next;
   logic   take;

   assign word = ucode_rom(pc_ff);
   assign pc_next = pc_ff + pc_type'(1);

   always_comb begin
      take = 1'b0;
      unique case (word.cond)
         COND_NONE:       take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_NO_REQ:     take = !flags.req_valid;
         COND_DISPATCH:   take = 1'b1;
         COND_NO_SCROLL:  take = flags.no_scroll;
         COND_MOVE_DONE:  take = flags.move_done;
         COND_SWEEP_BUSY: take = flags.sweep_busy;
         COND_DIV_BUSY:   take = flags.div_busy;
         COND_OUT_FREE:   take = flags.out_free;
         default:         take = 1'b1;
      endcase
   end

   always_comb begin
      if (word.cond == COND_DISPATCH) begin
         pc_in = flags.dispatch_pc;
      end else if (take) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: rtl/tcw_port_checker.sv
module tcw_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_pos,
   input logic [tcw_pkg::BYTE_W-1:0]    rsp_cell_char,
   input logic [tcw_pkg::BYTE_W-1:0]    rsp_cell_attr,
   input logic                          rsp_scrolled
);
   import tcw_pkg::*;

   logic req_acc;

   assign req_acc = req_valid && req_ready;

   // A request occupies the sequencer, so no word is taken on the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ready)
      else $error("request taken on two consecutive cycles");

   // A response needs several steps after its request is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !$rose(rsp_valid))
      else $error("response appeared right after a request");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_pos)
         && $stable(rsp_cell_char) && $stable(rsp_cell_attr) && $stable(rsp_scrolled))
      else $error("stalled response changed");

endmodule

bind text_console_writer tcw_port_checker u_port_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_cursor_pos (rsp_ch.cursor_pos),
   .rsp_cell_char  (rsp_ch.cell_char),
   .rsp_cell_attr  (rsp_ch.cell_attr),
   .rsp_scrolled   (rsp_ch.scrolled)
);
